// File: hdl/shabc_pkg.sv
`default_nettype none

package shabc_pkg;

  typedef logic [31:0] word_t;

  localparam int NUM_CHAIN = 8;
  localparam int NUM_ROUNDS = 64;
  localparam int NUM_WORDS = 16;

  localparam word_t INIT_IV [NUM_CHAIN] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: hdl/sha256_block_compress_core.sv
// sha-256 block compression core
// input channel: one 32-bit big-endian message word per beat on in_tdata,
//   in_tuser[0] = first_block (reload chaining value from init registers),
//   in_tuser[1] = final_block (sampled on the sixteenth word of a block)
// config channel: cfg_index 0..7 writes init_word_0..7, other indexes are
//   dropped; cfg_ready is always high
// output channel: after a final block, eight digest beats, out_tuser holds
//   the word position and out_tlast marks the eighth word
// timing: words are taken one per cycle while in_tready is high; after the
//   sixteenth word the block runs 64 rounds on one shared round unit, one
//   round per cycle, then the chaining add state, after which a final block
//   presents its first digest beat
// in_tready is low during the rounds, the chaining add and while the digest is sent; a stall
//   on out_tready holds the current digest beat and the core
// reset: loads the standard initial hash values into the init registers and
//   the chaining value, clears the word count and returns to word loading
`default_nettype none

module sha256_block_compress_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire shabc_pkg::word_t in_tdata,   // msg_word
  input  wire  [1:0]           in_tuser,   // first_block, final_block
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output shabc_pkg::word_t     out_tdata,  // digest_word
  output logic [2:0]           out_tuser,  // digest_index
  output logic                 out_tlast,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [3:0]           cfg_index,
  input  wire shabc_pkg::word_t cfg_data
);
  import shabc_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] wcnt_r, wcnt_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       final_r, final_nxt;
  word_t      init_r [NUM_CHAIN];
  word_t      init_nxt [NUM_CHAIN];
  word_t      chain_r [NUM_CHAIN];
  word_t      chain_nxt [NUM_CHAIN];
  word_t      work_r [NUM_CHAIN];
  word_t      work_nxt [NUM_CHAIN];
  word_t      win_r [NUM_WORDS];
  word_t      win_nxt [NUM_WORDS];
  word_t      chain_sel [NUM_CHAIN];
  word_t      t1, t2, w_new;
  logic       in_acc;

  assign in_tready  = (state_r == ST_LOAD);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = chain_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = &oidx_r;

  // shared round unit
  assign t1 = work_r[7] + bsig1(work_r[4])
            + (work_r[6] ^ ((work_r[5] ^ work_r[6]) & work_r[4]))
            + ROUND_K[rnd_r] + win_r[0];
  assign t2 = bsig0(work_r[0])
            + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
  // window holds w[t..t+15]; next schedule word is w[t+16]
  assign w_new = ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];

  always_comb begin
    for (int i = 0; i < NUM_CHAIN; i++) begin
      chain_sel[i] = in_tuser[0] ? init_r[i] : chain_r[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    final_nxt = final_r;
    init_nxt  = init_r;
    chain_nxt = chain_r;
    work_nxt  = work_r;
    win_nxt   = win_r;

    if (cfg_valid && cfg_index < 4'(NUM_CHAIN)) begin
      init_nxt[cfg_index[2:0]] = cfg_data;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          chain_nxt = chain_sel;
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            win_nxt[i] = win_r[i + 1];
          end
          win_nxt[NUM_WORDS - 1] = in_tdata;
          wcnt_nxt = wcnt_r + 4'd1;
          if (&wcnt_r) begin
            work_nxt  = chain_sel;
            final_nxt = in_tuser[1];
            rnd_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        for (int i = 0; i < NUM_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[NUM_WORDS - 1] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (&rnd_r) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < NUM_CHAIN; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        oidx_nxt  = '0;
        state_nxt = final_r ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (&oidx_r) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      wcnt_r  <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      final_r <= 1'b0;
      init_r  <= INIT_IV;
      chain_r <= INIT_IV;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      final_r <= final_nxt;
      init_r  <= init_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    win_r  <= win_nxt;
  end

endmodule

`default_nettype wire
